[hw/rtl/ema_with_sma_seed_assert.svh]
// Assertion macros for the SMA-seeded moving average block.
// Included by the top level; depends on nothing else.
`ifndef EMA_WITH_SMA_SEED_ASSERT_SVH
`define EMA_WITH_SMA_SEED_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset.
`define EMAS_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("ema_with_sma_seed: assertion failed");
// Expression must never be true outside reset.
`define EMAS_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("ema_with_sma_seed: forbidden condition");
`else
`define EMAS_ASSERT(lbl, clk, rstn, prop)
`define EMAS_NEVER(lbl, clk, rstn, expr)
`endif
`endif

[hw/rtl/emas_pkg.sv]
// Shared widths and types for the SMA-seeded moving average block.
// Used by emas_div and ema_with_sma_seed; depends on nothing.
`default_nettype none
package emas_pkg;
    localparam int PRICE_W  = 48;              // Q32.16 price and average
    localparam int SUM_W    = 64;              // warm-up running sum, divider dividend
    localparam int PERIOD_W = 16;              // period register and sample count
    localparam int DVS_W    = PERIOD_W + 1;    // divisor up to n+1
    localparam int STEP_W   = $clog2(SUM_W);   // divider step counter

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;
endpackage
`default_nettype wire

[hw/rtl/ema_with_sma_seed.sv]
// Channel   Direction  Handshake                 Payload
// in        to block   i_in_valid / o_in_stall   i_price[47:0]
// out       from block o_out_valid / i_out_stall o_average[47:0], o_seeded
// cfg       to block   i_cfg_valid / o_cfg_ready i_cfg_data[15:0] (period)
//
// One transaction is handled at a time. A warm-up price that does not form
// the seed passes through S_OUT into the output register; a seeding price or
// an EMA update first waits in S_DIV for the 64 steps of the shared
// bit-serial divider (one quotient bit per cycle), then passes through S_OUT.
// A new price is taken only once the block is back in S_IDLE. The next input
// is taken while a result still waits in the output register.
// Reset is synchronous, active low: period 10, empty sum, count zero, warming
// up, average zero. A stall on the output holds the finished result and,
// after one more result is computed, holds the block.
// Depends on emas_pkg, emas_div and ema_with_sma_seed_assert.svh.
`default_nettype none
`include "ema_with_sma_seed_assert.svh"
module ema_with_sma_seed import emas_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // input transaction
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [PRICE_W-1:0]  i_price,
    // output transaction
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic      [PRICE_W-1:0]  o_average,
    output logic                     o_seeded,
    // period register write
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [PERIOD_W-1:0] i_cfg_data
);
    localparam logic [1:0] S_IDLE = 2'd0;  // ready for a price
    localparam logic [1:0] S_DIV  = 2'd1;  // divider running
    localparam logic [1:0] S_OUT  = 2'd2;  // result waits for the output register

    logic [1:0]          r_state;
    logic [PERIOD_W-1:0] r_period;
    logic [SUM_W-1:0]    r_sum;
    logic [PERIOD_W-1:0] r_cnt;
    logic                r_warm;
    logic [PRICE_W-1:0]  r_avg;
    logic                r_out_valid;
    logic [PRICE_W-1:0]  r_out_average;
    logic                r_out_seeded;
    logic                r_seed_op;   // divider is forming the seed
    logic                r_sub;       // EMA step moves the average down

    logic                w_in_acc;
    logic                w_out_free;
    logic [PERIOD_W-1:0] w_eff_n;
    logic [SUM_W-1:0]    n_sum;
    logic [PERIOD_W-1:0] n_cnt;
    logic                w_seed_now;
    logic                w_below;
    logic [PRICE_W-1:0]  w_diff;
    logic                w_div_start;
    logic [SUM_W-1:0]    w_dividend;
    logic [DVS_W-1:0]    w_divisor;
    logic [SUM_W-1:0]    w_quo;
    logic [PRICE_W-1:0]  w_q;
    t_div_stat           w_div_stat;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    // output register may be loaded when empty or being emptied this cycle
    assign w_out_free = !r_out_valid || !i_out_stall;

    // a period of zero behaves as one
    assign w_eff_n = (r_period == '0) ? PERIOD_W'(1) : r_period;

    always_comb begin
        n_sum      = r_sum + SUM_W'(i_price);
        n_cnt      = r_cnt + 1'b1;
        // seed on reaching or passing the period, or on count wrap
        w_seed_now = (n_cnt >= w_eff_n) || (n_cnt == '0);
        w_below    = (i_price < r_avg);
        w_diff     = w_below ? (r_avg - i_price) : (i_price - r_avg);

        w_div_start = w_in_acc && (!r_warm || w_seed_now);
        if (r_warm) begin
            // simple mean of all prices so far
            w_dividend = n_sum;
            w_divisor  = (n_cnt == '0) ? DVS_W'(1) : {1'b0, n_cnt};
        end else begin
            // 2*|price - avg| / (n+1), magnitude truncated
            w_dividend = SUM_W'({w_diff, 1'b0});
            w_divisor  = {1'b0, w_eff_n} + DVS_W'(1);
        end
    end

    emas_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_quotient (w_quo),
        .o_stat     (w_div_stat)
    );

    // quotient never exceeds the sum mean or the difference, so 48 bits hold it
    assign w_q = w_quo[PRICE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_period    <= PERIOD_W'(10);
            r_sum       <= '0;
            r_cnt       <= '0;
            r_warm      <= 1'b1;
            r_avg       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_period <= i_cfg_data;
            end
            // drop the output once the consumer takes it
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (r_warm) begin
                            r_sum <= n_sum;
                            r_cnt <= n_cnt;
                        end
                        r_state <= w_div_start ? S_DIV : S_OUT;
                    end
                end
                S_DIV: begin
                    if (w_div_stat.done) begin
                        if (r_seed_op) begin
                            r_avg  <= w_q;
                            r_warm <= 1'b0;
                        end else if (r_sub) begin
                            r_avg <= r_avg - w_q;
                        end else begin
                            r_avg <= r_avg + w_q;
                        end
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_seed_op <= r_warm;
            r_sub     <= w_below;
        end
        if (r_state == S_OUT && w_out_free) begin
            r_out_average <= r_avg;
            r_out_seeded  <= !r_warm;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_average   = r_out_average;
    assign o_seeded    = r_out_seeded;
    assign o_cfg_ready = 1'b1;

    // divider finishes only while the sequencer waits for it
    `EMAS_ASSERT(a_done_in_div, i_clk, i_rst_n, w_div_stat.done |-> (r_state == S_DIV))
    // divider runs only while the sequencer waits for it
    `EMAS_ASSERT(a_busy_in_div, i_clk, i_rst_n, w_div_stat.busy |-> (r_state == S_DIV))
    // once seeded, the block never returns to warm-up
    `EMAS_ASSERT(a_seed_sticky, i_clk, i_rst_n, !r_warm |=> !r_warm)
    // the average stays zero until the seed is formed
    `EMAS_NEVER(a_avg_zero_warm, i_clk, i_rst_n, r_warm && (r_avg != '0))
    // a new result appears only from the hand-off state
    `EMAS_ASSERT(a_out_from_hold, i_clk, i_rst_n, $rose(r_out_valid) |-> ($past(r_state) == S_OUT))
endmodule
`default_nettype wire

[hw/rtl/emas_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on emas_pkg.
`default_nettype none
module emas_div import emas_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [SUM_W-1:0]  i_dividend,
    input  wire logic [DVS_W-1:0]  i_divisor,
    output logic      [SUM_W-1:0]  o_quotient,
    output t_div_stat              o_stat
);
    logic [SUM_W-1:0]  r_quo;
    logic [DVS_W-1:0]  r_rem;
    logic [DVS_W-1:0]  r_dvs;
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [DVS_W:0]    w_trial;
    logic [DVS_W:0]    w_diff;
    logic              w_fit;
    logic [DVS_W-1:0]  n_rem;

    // shift the next dividend bit into the partial remainder, trial subtract
    always_comb begin
        w_trial = {r_rem, r_quo[SUM_W-1]};
        w_diff  = w_trial - {1'b0, r_dvs};
        w_fit   = (w_trial >= {1'b0, r_dvs});
        n_rem   = w_fit ? w_diff[DVS_W-1:0] : w_trial[DVS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_W'(SUM_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[SUM_W-2:0], w_fit};
            r_rem <= n_rem;
        end
    end

    assign o_quotient  = r_quo;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
endmodule
`default_nettype wire
